/* rtl/core/threshold_centroid_finder_defines.svh */
// ----------------------------------------------------------------------------
// threshold centroid finder assertion macros
// Shared concurrent assertion forms for the centroid finder modules.
// ----------------------------------------------------------------------------
`ifndef THRESHOLD_CENTROID_FINDER_DEFINES_SVH
`define THRESHOLD_CENTROID_FINDER_DEFINES_SVH

// same-cycle implication, checked outside reset
`define TCF_ASSERT_IMP(lbl, clk_s, rst_s, ante, cons) \
    lbl: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |-> (cons)) \
        else $error("centroid finder assertion failed");

// next-cycle implication, checked outside reset
`define TCF_ASSERT_NXT(lbl, clk_s, rst_s, ante, cons) \
    lbl: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |=> (cons)) \
        else $error("centroid finder assertion failed");

`endif

/* rtl/core/tcf_pkg.sv */
// ----------------------------------------------------------------------------
// tcf_pkg
// Types and fixed constants shared by the centroid finder modules.
// ----------------------------------------------------------------------------
`default_nettype none

package tcf_pkg;

    // fixed field widths
    localparam int PIX_W      = 8;
    localparam int THR_W      = 9;
    localparam int DIM_W      = 13;
    localparam int CEN_W      = 12;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 13;

    // register reset values
    localparam logic [THR_W-1:0] THRESHOLD_RESET = THR_W'(125);
    localparam logic [DIM_W-1:0] WIDTH_RESET     = DIM_W'(640);
    localparam logic [DIM_W-1:0] HEIGHT_RESET    = DIM_W'(480);

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_WIDTH     = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] REG_HEIGHT    = CFG_IDX_W'(2);

    // controller states
    typedef enum logic [1:0] {
        ST_RUN,
        ST_DIVIDE,
        ST_LOAD
    } tcf_state_t;

    // controller to datapath
    typedef struct packed {
        logic pixel_take;
        logic div_start;
        logic div_step;
        logic result_load;
    } tcf_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic last_pixel;
    } tcf_status_t;

endpackage

`default_nettype wire

/* rtl/core/tcf_datapath.sv */
// ----------------------------------------------------------------------------
// tcf_datapath
// Config registers, raster position, bright sums and the shared divider.
// ----------------------------------------------------------------------------
`default_nettype none
`include "threshold_centroid_finder_defines.svh"

module tcf_datapath
    import tcf_pkg::*;
#(
    parameter int MAX_WIDTH  = 4096,
    parameter int MAX_HEIGHT = 4096,
    parameter int COL_W      = 12,
    parameter int ROW_W      = 12,
    parameter int CNT_W      = 25,
    parameter int SUM_W      = 36
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  cfg_valid,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data,
    input  wire logic [PIX_W-1:0]      pixel_value,
    input  wire tcf_cmd_t              cmd,
    output tcf_status_t                status,
    output logic [CEN_W-1:0]           centroid_x,
    output logic [CEN_W-1:0]           centroid_y
);

    localparam int WB_W  = $clog2(MAX_WIDTH + 1);
    localparam int HB_W  = $clog2(MAX_HEIGHT + 1);
    localparam int EXT_A = (WB_W > HB_W) ? WB_W : HB_W;
    localparam int EXT_W = (EXT_A > DIM_W) ? EXT_A : DIM_W;
    localparam int QX_W  = (SUM_W > CEN_W) ? SUM_W : CEN_W;

    logic [THR_W-1:0] thr_reg;
    logic [DIM_W-1:0] width_reg;
    logic [DIM_W-1:0] height_reg;

    logic [COL_W-1:0] col_reg;
    logic [ROW_W-1:0] row_reg;
    logic [SUM_W-1:0] col_sum_reg;
    logic [SUM_W-1:0] row_sum_reg;
    logic [CNT_W-1:0] count_reg;

    logic [SUM_W-1:0] cq_col_reg;
    logic [SUM_W-1:0] cq_row_reg;
    logic [CNT_W-1:0] cr_col_reg;
    logic [CNT_W-1:0] cr_row_reg;
    logic [CNT_W-1:0] div_reg;
    logic             zero_reg;

    logic [CEN_W-1:0] centroid_x_reg;
    logic [CEN_W-1:0] centroid_y_reg;

    logic [EXT_W-1:0] w_eff;
    logic [EXT_W-1:0] h_eff;
    logic [EXT_W-1:0] w_last;
    logic [EXT_W-1:0] h_last;
    logic             row_end;
    logic             frame_end;
    logic             bright;

    logic [SUM_W-1:0] col_sum_next;
    logic [SUM_W-1:0] row_sum_next;
    logic [CNT_W-1:0] count_next;

    logic [CNT_W:0]   trial_col;
    logic [CNT_W:0]   trial_row;
    logic [CNT_W:0]   diff_col;
    logic [CNT_W:0]   diff_row;
    logic             fit_col;
    logic             fit_row;
    logic [QX_W-1:0]  qx_col;
    logic [QX_W-1:0]  qx_row;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_reg    <= THRESHOLD_RESET;
            width_reg  <= WIDTH_RESET;
            height_reg <= HEIGHT_RESET;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                REG_THRESHOLD: thr_reg    <= cfg_data[THR_W-1:0];
                REG_WIDTH:     width_reg  <= cfg_data[DIM_W-1:0];
                REG_HEIGHT:    height_reg <= cfg_data[DIM_W-1:0];
                default:       ;
            endcase
        end
    end

    // clamp frame size to one and to the maximum
    always_comb
    begin
        if (width_reg == '0)
            w_eff = EXT_W'(1);
        else if (EXT_W'(width_reg) > EXT_W'(MAX_WIDTH))
            w_eff = EXT_W'(MAX_WIDTH);
        else
            w_eff = EXT_W'(width_reg);

        if (height_reg == '0)
            h_eff = EXT_W'(1);
        else if (EXT_W'(height_reg) > EXT_W'(MAX_HEIGHT))
            h_eff = EXT_W'(MAX_HEIGHT);
        else
            h_eff = EXT_W'(height_reg);
    end

    // end of row and end of frame
    assign w_last    = w_eff - EXT_W'(1);
    assign h_last    = h_eff - EXT_W'(1);
    assign row_end   = EXT_W'(col_reg) >= w_last;
    assign frame_end = row_end && (EXT_W'(row_reg) >= h_last);
    assign status.last_pixel = frame_end;

    // bright test and accumulation
    assign bright       = {1'b0, pixel_value} >= thr_reg;
    assign col_sum_next = col_sum_reg + (bright ? SUM_W'(col_reg) : '0);
    assign row_sum_next = row_sum_reg + (bright ? SUM_W'(row_reg) : '0);
    assign count_next   = count_reg + CNT_W'(bright);

    // raster position and sums
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg     <= '0;
            row_reg     <= '0;
            col_sum_reg <= '0;
            row_sum_reg <= '0;
            count_reg   <= '0;
        end
        else if (cmd.pixel_take)
        begin
            if (frame_end)
            begin
                col_reg     <= '0;
                row_reg     <= '0;
                col_sum_reg <= '0;
                row_sum_reg <= '0;
                count_reg   <= '0;
            end
            else
            begin
                col_sum_reg <= col_sum_next;
                row_sum_reg <= row_sum_next;
                count_reg   <= count_next;
                if (!row_end)
                begin
                    col_reg <= col_reg + COL_W'(1);
                end
                else
                begin
                    col_reg <= '0;
                    row_reg <= row_reg + ROW_W'(1);
                end
            end
        end
    end

    // restoring divide step, both sums share the divisor
    assign trial_col = {cr_col_reg, cq_col_reg[SUM_W-1]};
    assign trial_row = {cr_row_reg, cq_row_reg[SUM_W-1]};
    assign diff_col  = trial_col - {1'b0, div_reg};
    assign diff_row  = trial_row - {1'b0, div_reg};
    assign fit_col   = trial_col >= {1'b0, div_reg};
    assign fit_row   = trial_row >= {1'b0, div_reg};

    // divider registers
    always_ff @(posedge clk)
    begin
        if (cmd.div_start)
        begin
            cq_col_reg <= col_sum_next;
            cq_row_reg <= row_sum_next;
            cr_col_reg <= '0;
            cr_row_reg <= '0;
            div_reg    <= count_next;
            zero_reg   <= (count_next == '0);
        end
        else if (cmd.div_step)
        begin
            cq_col_reg <= {cq_col_reg[SUM_W-2:0], fit_col};
            cq_row_reg <= {cq_row_reg[SUM_W-2:0], fit_row};
            cr_col_reg <= fit_col ? diff_col[CNT_W-1:0] : trial_col[CNT_W-1:0];
            cr_row_reg <= fit_row ? diff_row[CNT_W-1:0] : trial_row[CNT_W-1:0];
        end
    end

    // result register
    assign qx_col = QX_W'(cq_col_reg);
    assign qx_row = QX_W'(cq_row_reg);

    always_ff @(posedge clk)
    begin
        if (cmd.result_load)
        begin
            centroid_x_reg <= zero_reg ? '0 : qx_col[CEN_W-1:0];
            centroid_y_reg <= zero_reg ? '0 : qx_row[CEN_W-1:0];
        end
    end

    assign centroid_x = centroid_x_reg;
    assign centroid_y = centroid_y_reg;

    // checks
    `TCF_ASSERT_NXT(a_frame_clear, clk, rst_n, cmd.pixel_take && frame_end,
        col_reg == '0 && row_reg == '0 && count_reg == '0)
    `TCF_ASSERT_NXT(a_count_step, clk, rst_n, cmd.pixel_take && !frame_end,
        count_reg == $past(count_next))
    `TCF_ASSERT_IMP(a_rem_below_div, clk, rst_n, cmd.div_step && !zero_reg,
        cr_col_reg < div_reg && cr_row_reg < div_reg)

endmodule

`default_nettype wire

/* rtl/core/tcf_controller.sv */
// ----------------------------------------------------------------------------
// tcf_controller
// Sequences pixel intake, the per-frame divide and the result handoff.
// ----------------------------------------------------------------------------
`default_nettype none
`include "threshold_centroid_finder_defines.svh"

module tcf_controller
    import tcf_pkg::*;
#(
    parameter int DIV_STEPS = 36
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        pixel_valid,
    output logic             pixel_stall,
    output logic             centroid_valid,
    input  wire logic        centroid_stall,
    input  wire tcf_status_t status,
    output tcf_cmd_t         cmd
);

    localparam int STEP_W = (DIV_STEPS > 1) ? $clog2(DIV_STEPS) : 1;

    tcf_state_t        state_reg;
    tcf_state_t        state_next;
    logic [STEP_W-1:0] step_reg;
    logic [STEP_W-1:0] step_next;
    logic              out_valid_reg;
    logic              out_valid_next;

    // state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_RUN;
            step_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            step_reg      <= step_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // next state and commands
    always_comb
    begin
        state_next  = state_reg;
        step_next   = step_reg;
        cmd         = '0;
        pixel_stall = 1'b1;

        case (state_reg)
            ST_RUN:
            begin
                pixel_stall    = 1'b0;
                cmd.pixel_take = pixel_valid;
                if (pixel_valid && status.last_pixel)
                begin
                    cmd.div_start = 1'b1;
                    step_next     = '0;
                    state_next    = ST_DIVIDE;
                end
            end
            ST_DIVIDE:
            begin
                cmd.div_step = 1'b1;
                step_next    = step_reg + STEP_W'(1);
                if (step_reg == STEP_W'(DIV_STEPS - 1))
                    state_next = ST_LOAD;
            end
            ST_LOAD:
            begin
                if (!out_valid_reg || !centroid_stall)
                begin
                    cmd.result_load = 1'b1;
                    state_next      = ST_RUN;
                end
            end
            default:
            begin
                state_next = ST_RUN;
            end
        endcase
    end

    // output request flag
    always_comb
    begin
        if (cmd.result_load)
            out_valid_next = 1'b1;
        else if (out_valid_reg && !centroid_stall)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    assign centroid_valid = out_valid_reg;

    // checks
    `TCF_ASSERT_NXT(a_start_divide, clk, rst_n, cmd.div_start,
        state_reg == ST_DIVIDE && step_reg == '0)
    `TCF_ASSERT_NXT(a_load_valid, clk, rst_n, cmd.result_load, centroid_valid)
    `TCF_ASSERT_IMP(a_no_overwrite, clk, rst_n, cmd.result_load,
        !out_valid_reg || !centroid_stall)

endmodule

`default_nettype wire

/* rtl/core/threshold_centroid_finder.sv */
// ----------------------------------------------------------------------------
// threshold_centroid_finder
// Mean column and row of pixels at or above a threshold, one result per frame.
// ----------------------------------------------------------------------------
// throughput: one pixel per cycle inside a frame
// frame end: the last pixel starts a restoring divide of SUM_W steps (36 at
//   the default size), pixel input stalls during it and while the result loads
// result: loaded after the divide, once any earlier centroid has been taken
// reset: threshold 125, size 640 x 480, position, sums and count cleared
// ----------------------------------------------------------------------------
`default_nettype none

module threshold_centroid_finder
    import tcf_pkg::*;
#(
    parameter int MAX_WIDTH  = 4096,
    parameter int MAX_HEIGHT = 4096
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  cfg_valid,
    output logic                       cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data,
    input  wire logic                  pixel_valid,
    output logic                       pixel_stall,
    input  wire logic [PIX_W-1:0]      pixel_value,
    output logic                       centroid_valid,
    input  wire logic                  centroid_stall,
    output logic [CEN_W-1:0]           centroid_x,
    output logic [CEN_W-1:0]           centroid_y
);

    localparam int COL_W = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int ROW_W = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
    localparam longint unsigned PIX_MAX = longint'(MAX_WIDTH) * longint'(MAX_HEIGHT);
    localparam int LOG_PIX = (PIX_MAX > 2) ? $clog2(PIX_MAX) : 1;
    localparam int CNT_W = $clog2(PIX_MAX + 1);
    localparam int SUM_W = ((COL_W > ROW_W) ? COL_W : ROW_W) + LOG_PIX;

    tcf_cmd_t    cmd;
    tcf_status_t status;

    // registers are always writable
    assign cfg_ready = 1'b1;

    tcf_controller #(
        .DIV_STEPS (SUM_W)
    ) u_ctrl (
        .clk            (clk),
        .rst_n          (rst_n),
        .pixel_valid    (pixel_valid),
        .pixel_stall    (pixel_stall),
        .centroid_valid (centroid_valid),
        .centroid_stall (centroid_stall),
        .status         (status),
        .cmd            (cmd)
    );

    tcf_datapath #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT),
        .COL_W      (COL_W),
        .ROW_W      (ROW_W),
        .CNT_W      (CNT_W),
        .SUM_W      (SUM_W)
    ) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_valid   (cfg_valid),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .pixel_value (pixel_value),
        .cmd         (cmd),
        .status      (status),
        .centroid_x  (centroid_x),
        .centroid_y  (centroid_y)
    );

endmodule

`default_nettype wire
